[hdl/assert_macros.svh]
// assertion macros for the rtl, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(label, a, c) label: assert property (@(posedge clk) disable iff (!arst_n) \
	(a) |-> (c)) else $error("assertion failed");
`define ASSERT_DELAY(label, a, n, c) label: assert property (@(posedge clk) disable iff (!arst_n) \
	(a) |-> ##n (c)) else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, a, c)
`define ASSERT_DELAY(label, a, n, c)
`endif
`endif

[hdl/pcpf_pkg.sv]
// shared types, constants and rotation helpers for the prime form pipeline
package pcpf_pkg;

	localparam int MAX_CLASSES  = 24;
	localparam int BASE_CLASSES = 12;
	localparam int MASK_W       = 24;
	localparam int CARD_W       = 5;
	localparam int SET_W        = MAX_CLASSES;
	localparam int CNT_W        = $clog2(MAX_CLASSES + 1);
	localparam int LATENCY      = MAX_CLASSES + 1;

	localparam logic [SET_W-1:0] BASE_MASK = SET_W'((64'd1 << BASE_CLASSES) - 64'd1);

	typedef logic [SET_W-1:0] set_t;

	typedef struct packed {
		logic             mode;
		set_t             set;
		set_t             inv;
		set_t             pending;
		set_t             best;
		logic             have;
		logic [CNT_W-1:0] count;
	} pcpf_data_t;

	// rotate down by one pitch class within the selected modulus
	function automatic set_t rot1(input set_t x, input logic mode);
		set_t r;
		if (mode) begin
			r = {x[0], x[SET_W-1:1]};
		end else begin
			r = (x >> 1) & BASE_MASK;
			r[BASE_CLASSES-1] = x[0];
		end
		return r;
	endfunction

	// x -> -x mod m
	function automatic set_t invert(input set_t x, input logic mode);
		set_t r;
		r = '0;
		for (int j = 0; j < SET_W; j++) begin
			if (mode) begin
				r[j] = x[(j == 0) ? 0 : (SET_W - j)];
			end else if (j < BASE_CLASSES) begin
				r[j] = x[(j == 0) ? 0 : (BASE_CLASSES - j)];
			end
		end
		return r;
	endfunction

endpackage

[hdl/pcpf_entry.sv]
// entry stage: masks the set to the modulus and forms its inversion
module pcpf_entry (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [23:0]               member_mask,
	input  logic                      mode,
	output logic                      valid_out,
	output pcpf_pkg::pcpf_data_t      data_out
);
	import pcpf_pkg::*;

	set_t       masked;
	logic       valid_s1;
	pcpf_data_t data_s1;

	assign masked = SET_W'(member_mask) & (mode ? {SET_W{1'b1}} : BASE_MASK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			data_s1.mode    <= mode;
			data_s1.set     <= masked;
			data_s1.inv     <= invert(masked, mode);
			data_s1.pending <= masked;
			data_s1.best    <= '0;
			data_s1.have    <= 1'b0;
			data_s1.count   <= '0;
		end
	end

	assign valid_out = valid_s1;
	assign data_out  = data_s1;

endmodule

[hdl/pcpf_cell.sv]
// one rotation cell: tests the current rotations, keeps the smallest, rotates on
module pcpf_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_in,
	input  pcpf_pkg::pcpf_data_t      data_in,
	output logic                      valid_out,
	output pcpf_pkg::pcpf_data_t      data_out
);
	import pcpf_pkg::*;

	logic       take_set;
	logic       take_inv;
	logic       cand_ok;
	set_t       cand;
	set_t       best_nxt;
	logic       valid_s1;
	pcpf_data_t data_s1;

	assign take_set = data_in.set[0];
	assign take_inv = data_in.inv[0];
	assign cand_ok  = take_set | take_inv;

	always_comb begin
		if (take_set && take_inv) begin
			cand = (data_in.inv < data_in.set) ? data_in.inv : data_in.set;
		end else if (take_set) begin
			cand = data_in.set;
		end else begin
			cand = data_in.inv;
		end
		if (cand_ok && (!data_in.have || (cand < data_in.best))) begin
			best_nxt = cand;
		end else begin
			best_nxt = data_in.best;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_in) begin
			data_s1.mode    <= data_in.mode;
			data_s1.set     <= rot1(data_in.set, data_in.mode);
			data_s1.inv     <= rot1(data_in.inv, data_in.mode);
			data_s1.pending <= data_in.pending >> 1;
			data_s1.best    <= best_nxt;
			data_s1.have    <= data_in.have | cand_ok;
			data_s1.count   <= data_in.count + CNT_W'(data_in.pending[0]);
		end
	end

	assign valid_out = valid_s1;
	assign data_out  = data_s1;

endmodule

[hdl/pitch_class_prime_form_top.sv]
// Prime form of a pitch-class set under transposition and inversion, Rahn ordering.
// A new set is taken on every clock (busy is always low) and its result appears on
// done, prime_form_mask and cardinality after passing one entry stage that masks
// and inverts the set, then one rotation cell per pitch class of the larger modulus,
// each a register stage. The result is shown for a single cycle and cannot be held off,
// so the receiver must take it when done is high.
`include "assert_macros.svh"
module pitch_class_prime_form_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [23:0] member_mask,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	output logic        done,
	output logic [23:0] prime_form_mask,
	output logic [4:0]  cardinality
);
	import pcpf_pkg::*;

	logic       modulus_select_q;
	logic       chain_v [MAX_CLASSES+1];
	pcpf_data_t chain_d [MAX_CLASSES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_select_q <= 1'b1;
		end else if (cfg_wr_en) begin
			modulus_select_q <= cfg_wr_data;
		end
	end

	assign busy = 1'b0;

	pcpf_entry u_entry (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start && !busy),
		.member_mask (member_mask),
		.mode        (modulus_select_q),
		.valid_out   (chain_v[0]),
		.data_out    (chain_d[0])
	);

	for (genvar i = 0; i < MAX_CLASSES; i++) begin : g_cell
		pcpf_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (chain_v[i]),
			.data_in   (chain_d[i]),
			.valid_out (chain_v[i+1]),
			.data_out  (chain_d[i+1])
		);
	end

	assign done            = chain_v[MAX_CLASSES];
	assign prime_form_mask = MASK_W'(chain_d[MAX_CLASSES].best);
	assign cardinality     = CARD_W'(chain_d[MAX_CLASSES].count);

	`ASSERT_DELAY(a_transfer_latency, start && !busy, LATENCY, done)
	`ASSERT_IMPLY(a_empty_gives_zero, done && (cardinality == '0), prime_form_mask == '0)
	`ASSERT_IMPLY(a_prime_has_zero, done && chain_d[MAX_CLASSES].have, prime_form_mask[0])

endmodule
